/* rtl/core/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// shared constants, codes and types of the set-associative lru tag store
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MAX_WAYS_DEF  = 8;
  localparam int MAX_SETS_DEF  = 512;
  localparam int ADDR_BITS_DEF = 32;

  localparam int OFFSET_LIMIT = 12;
  localparam int INDEX_LIMIT  = 9;

  localparam int CFG_W     = 4;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int COUNT_W   = 32;
  localparam int WAY_OUT_W = 3;

  localparam logic [CFG_W-1:0] OFFSET_RST = 4'd6;
  localparam logic [CFG_W-1:0] INDEX_RST  = 4'd4;
  localparam logic [CFG_W-1:0] WAYS_RST   = 4'd1;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_INDEX  = 2'd1;
  localparam logic [1:0] REG_WAYS   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [WAY_OUT_W-1:0] way;
  } lookup_res_t;

endpackage

/* rtl/core/salc_ram.sv */
// ----------------------------------------------------------------------------
// salc_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/salc_lookup.sv */
// ----------------------------------------------------------------------------
// salc_lookup
// tag compare, fill or victim choice and age rank update of one set row
// ----------------------------------------------------------------------------
module salc_lookup #(
  parameter int MAX_WAYS  = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF,
  parameter int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  parameter int NW_W      = $clog2(MAX_WAYS + 1),
  parameter int ENTRY_W   = 1 + ADDR_BITS + RANK_W,
  parameter int ROW_W     = MAX_WAYS * ENTRY_W
) (
  input  logic [ROW_W-1:0]     row_i,
  input  logic [ADDR_BITS-1:0] tag_i,
  input  logic [NW_W-1:0]      nways_i,
  output logic [ROW_W-1:0]     row_o,
  output salc_pkg::lookup_res_t res_o
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [RANK_W:0] RANK_CAP  = (RANK_W + 1)'(MAX_WAYS - 1);
  localparam logic [RANK_W:0] RANK_FILL = (RANK_W + 1)'(MAX_WAYS);

  logic                 valid [MAX_WAYS];
  logic [ADDR_BITS-1:0] tag   [MAX_WAYS];
  logic [RANK_W-1:0]    rank  [MAX_WAYS];
  logic [RANK_W-1:0]    rank_new [MAX_WAYS];

  logic              hit, free;
  logic [WAY_W-1:0]  hit_way, free_way, vic_way, way;
  logic [RANK_W-1:0] best;
  logic [RANK_W:0]   old_rank;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      rank[i]  = row_i[i*ENTRY_W +: RANK_W];
      tag[i]   = row_i[i*ENTRY_W + RANK_W +: ADDR_BITS];
      valid[i] = row_i[i*ENTRY_W + RANK_W + ADDR_BITS];
    end
  end

  // lowest way that hits, lowest invalid way, lowest way of highest rank
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    best     = '0;
    vic_way  = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < int'(nways_i)) begin
        if (valid[i] && tag[i] == tag_i) begin
          hit     = 1'b1;
          hit_way = WAY_W'(i);
        end
        if (!valid[i]) begin
          free     = 1'b1;
          free_way = WAY_W'(i);
        end
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < int'(nways_i) && rank[i] > best) begin
        best    = rank[i];
        vic_way = WAY_W'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      way = hit_way;
    end else if (free) begin
      way = free_way;
    end else begin
      way = vic_way;
    end
    if (!hit && free) begin
      old_rank = RANK_FILL;
    end else begin
      old_rank = {1'b0, rank[way]};
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      rank_new[i] = rank[i];
      if (WAY_W'(i) == way) begin
        rank_new[i] = '0;
      end else if (i < int'(nways_i) && valid[i] && {1'b0, rank[i]} < old_rank
                   && {1'b0, rank[i]} < RANK_CAP) begin
        rank_new[i] = rank[i] + RANK_W'(1);
      end
    end
  end

  always_comb begin
    row_o = row_i;
    for (int i = 0; i < MAX_WAYS; i++) begin
      row_o[i*ENTRY_W +: RANK_W] = rank_new[i];
    end
    if (!hit) begin
      row_o[int'(way)*ENTRY_W + RANK_W +: ADDR_BITS] = tag_i;
      row_o[int'(way)*ENTRY_W + RANK_W + ADDR_BITS]  = 1'b1;
    end
  end

  assign res_o.hit     = hit;
  assign res_o.evicted = !hit && !free;
  assign res_o.way     = salc_pkg::WAY_OUT_W'(way);

endmodule

/* rtl/core/set_associative_lru_cache_tags_top.sv */
// ----------------------------------------------------------------------------
// set_associative_lru_cache_tags_top
// tag store of a set-associative cache with lru replacement
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. The set row is read
// from the tag ram in that cycle, the next cycle compares tags, picks the way
// and writes the row back, and the result is shown on the result ports with
// result_valid_o for one cycle after that. busy is low again in the result
// cycle, so a new access can be taken while the result is shown. The read and
// the write-back share the single tag ram port. The result cannot be held
// off: take it in the cycle it is strobed. After reset, and after every write
// to a mapped register, a clearing pass runs through every set of the tag ram
// with busy high; it also zeroes both counters.
// ----------------------------------------------------------------------------
module set_associative_lru_cache_tags_top #(
  parameter int MAX_WAYS  = salc_pkg::MAX_WAYS_DEF,
  parameter int MAX_SETS  = salc_pkg::MAX_SETS_DEF,
  parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ADDR_BITS-1:0]                  address_i,
  output logic                                  result_valid_o,
  output logic                                  hit_o,
  output logic [salc_pkg::WAY_OUT_W-1:0]        way_used_o,
  output logic                                  evicted_o,
  output logic [salc_pkg::COUNT_W-1:0]          access_count_o,
  output logic [salc_pkg::COUNT_W-1:0]          miss_count_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]          paddr,
  input  logic [salc_pkg::PDATA_W-1:0]          pwdata,
  output logic [salc_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W    = $clog2(MAX_WAYS + 1);
  localparam int ENTRY_W = 1 + ADDR_BITS + RANK_W;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RAW_W   = salc_pkg::INDEX_LIMIT;
  localparam int CW      = salc_pkg::CFG_W;
  localparam int SH_W    = CW + 1;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);
  localparam logic [salc_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  salc_pkg::state_e state_q, state_d;

  logic [CW-1:0]        offset_q, offset_d, index_q, index_d, ways_q, ways_d;
  logic [SET_W-1:0]     clr_q, clr_d, set_q, set_d;
  logic [ADDR_BITS-1:0] tag_q, tag_d;
  logic [salc_pkg::COUNT_W-1:0] acc_q, acc_d, miss_q, miss_d;
  logic                 rvalid_q, rvalid_d;
  salc_pkg::lookup_res_t res_q, res_d, lk_res;

  logic                 accept, cfg_we, cfg_hit;
  logic [1:0]           cfg_idx;
  logic [CW-1:0]        off_eff, idx_eff;
  logic [NW_W-1:0]      nways;
  logic [ADDR_BITS-1:0] shifted;
  logic [RAW_W-1:0]     raw_idx, idx_mask, red_idx;
  logic [SET_W-1:0]     set_in;
  logic [ADDR_BITS-1:0] tag_in;

  logic                 ram_re, ram_we;
  logic [SET_W-1:0]     ram_addr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata, row_new;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_hit = cfg_we && (cfg_idx == salc_pkg::REG_OFFSET ||
                              cfg_idx == salc_pkg::REG_INDEX ||
                              cfg_idx == salc_pkg::REG_WAYS);

  always_comb begin
    case (cfg_idx)
      salc_pkg::REG_OFFSET: prdata = salc_pkg::PDATA_W'(offset_q);
      salc_pkg::REG_INDEX:  prdata = salc_pkg::PDATA_W'(index_q);
      salc_pkg::REG_WAYS:   prdata = salc_pkg::PDATA_W'(ways_q);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    offset_d = offset_q;
    index_d  = index_q;
    ways_d   = ways_q;
    if (cfg_we) begin
      case (cfg_idx)
        salc_pkg::REG_OFFSET: offset_d = pwdata[CW-1:0];
        salc_pkg::REG_INDEX:  index_d  = pwdata[CW-1:0];
        salc_pkg::REG_WAYS:   ways_d   = pwdata[CW-1:0];
        default:              ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    off_eff = (offset_q > CW'(salc_pkg::OFFSET_LIMIT)) ? CW'(salc_pkg::OFFSET_LIMIT)
                                                       : offset_q;
    idx_eff = (index_q > CW'(salc_pkg::INDEX_LIMIT)) ? CW'(salc_pkg::INDEX_LIMIT)
                                                     : index_q;
    if (ways_q == '0) begin
      nways = NW_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      nways = NW_W'(MAX_WAYS);
    end else begin
      nways = NW_W'(ways_q);
    end
  end

  // address split and set index reduction modulo MAX_SETS
  always_comb begin
    shifted  = address_i >> off_eff;
    idx_mask = RAW_W'(((RAW_W + 1)'(1) << idx_eff) - (RAW_W + 1)'(1));
    raw_idx  = shifted[RAW_W-1:0] & idx_mask;
    red_idx  = raw_idx;
    for (int k = RAW_W; k >= 0; k--) begin
      if ((MAX_SETS << k) < (1 << RAW_W)) begin
        if (red_idx >= RAW_W'(MAX_SETS << k)) begin
          red_idx = red_idx - RAW_W'(MAX_SETS << k);
        end
      end
    end
    set_in = SET_W'(red_idx);
    tag_in = address_i >> (SH_W'(off_eff) + SH_W'(idx_eff));
  end

  assign busy   = (state_q != salc_pkg::ST_IDLE);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      salc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = salc_pkg::ST_UPDATE;
        end
      end
      salc_pkg::ST_UPDATE: begin
        state_d = salc_pkg::ST_IDLE;
      end
      salc_pkg::ST_CLEAR: begin
        if (clr_q == LAST_SET) begin
          state_d = salc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = salc_pkg::ST_IDLE;
      end
    endcase
    if (cfg_hit) begin
      state_d = salc_pkg::ST_CLEAR;
    end
  end

  // outputs of the state machine
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = set_in;
    ram_wdata = row_new;
    rvalid_d  = 1'b0;
    res_d     = res_q;
    clr_d     = clr_q;
    set_d     = set_q;
    tag_d     = tag_q;
    acc_d     = acc_q;
    miss_d    = miss_q;
    case (state_q)
      salc_pkg::ST_IDLE: begin
        if (accept) begin
          ram_re = 1'b1;
          set_d  = set_in;
          tag_d  = tag_in;
        end
      end
      salc_pkg::ST_UPDATE: begin
        ram_we   = 1'b1;
        ram_addr = set_q;
        rvalid_d = 1'b1;
        res_d    = lk_res;
        if (acc_q != COUNT_MAX) begin
          acc_d = acc_q + 1'b1;
        end
        if (!lk_res.hit && miss_q != COUNT_MAX) begin
          miss_d = miss_q + 1'b1;
        end
      end
      salc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      default: ;
    endcase
    if (cfg_hit) begin
      clr_d  = '0;
      acc_d  = '0;
      miss_d = '0;
    end
  end

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .re_i   (ram_re),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  salc_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .ADDR_BITS(ADDR_BITS)
  ) u_lookup (
    .row_i  (ram_rdata),
    .tag_i  (tag_q),
    .nways_i(nways),
    .row_o  (row_new),
    .res_o  (lk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= salc_pkg::ST_CLEAR;
      offset_q <= salc_pkg::OFFSET_RST;
      index_q  <= salc_pkg::INDEX_RST;
      ways_q   <= salc_pkg::WAYS_RST;
      clr_q    <= '0;
      acc_q    <= '0;
      miss_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      offset_q <= offset_d;
      index_q  <= index_d;
      ways_q   <= ways_d;
      clr_q    <= clr_d;
      acc_q    <= acc_d;
      miss_q   <= miss_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
    tag_q <= tag_d;
    res_q <= res_d;
  end

  assign result_valid_o = rvalid_q;
  assign hit_o          = res_q.hit;
  assign way_used_o     = res_q.way;
  assign evicted_o      = res_q.evicted;
  assign access_count_o = acc_q;
  assign miss_count_o   = miss_q;

endmodule

/* tb/tb_set_associative_lru_cache_tags_top.sv */
// ----------------------------------------------------------------------------
// tb_set_associative_lru_cache_tags_top
// self-checking bench for the set-associative lru tag store
// ----------------------------------------------------------------------------
// Each accepted access goes through a local tag store model with per-way age
// ranks, and every strobed result is compared field by field with the oldest
// predicted one. Register writes go over the apb port between phases, once
// every result is in. The phases walk the offset, index and way settings,
// their clamped values included. Accesses come in bursts with random gaps and
// mostly hit a few hot sets with a small tag pool, so hits, fills and
// evictions all occur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_set_associative_lru_cache_tags_top;

  localparam int SETS        = salc_pkg::MAX_SETS_DEF;
  localparam int WAYS        = salc_pkg::MAX_WAYS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 50;

  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    OP_ACCESS,
    OP_WRITE,
    OP_DRAIN
  } trace_op_e;

  typedef enum logic [1:0] {
    APB_IDLE,
    APB_SETUP,
    APB_ACCESS
  } apb_phase_e;

  typedef struct {
    trace_op_e                      op;
    logic [31:0]                    addr;
    logic [salc_pkg::PADDR_W-1:0]   reg_addr;
    logic [salc_pkg::PDATA_W-1:0]   reg_data;
  } trace_item_t;

  typedef struct packed {
    salc_pkg::lookup_res_t          res;
    logic [salc_pkg::COUNT_W-1:0]   accesses;
    logic [salc_pkg::COUNT_W-1:0]   misses;
  } tag_result_t;

  logic                             clk_i   = 1'b0;
  logic                             rst_ni  = 1'b0;
  logic                             start   = 1'b0;
  logic [31:0]                      address_i = '0;
  logic                             psel    = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite  = 1'b0;
  logic [salc_pkg::PADDR_W-1:0]     paddr   = '0;
  logic [salc_pkg::PDATA_W-1:0]     pwdata  = '0;
  logic                             busy;
  logic                             result_valid_o;
  logic                             hit_o;
  logic [salc_pkg::WAY_OUT_W-1:0]   way_used_o;
  logic                             evicted_o;
  logic [salc_pkg::COUNT_W-1:0]     access_count_o;
  logic [salc_pkg::COUNT_W-1:0]     miss_count_o;
  logic [salc_pkg::PDATA_W-1:0]     prdata;
  logic                             pready;

  // model of the tag store
  logic [salc_pkg::CFG_W-1:0]       cfg_offset = salc_pkg::OFFSET_RST;
  logic [salc_pkg::CFG_W-1:0]       cfg_index  = salc_pkg::INDEX_RST;
  logic [salc_pkg::CFG_W-1:0]       cfg_ways   = salc_pkg::WAYS_RST;
  bit                               valid_q [SETS][WAYS];
  logic [31:0]                      tag_q   [SETS][WAYS];
  bit   [2:0]                       rank_q  [SETS][WAYS];
  logic [salc_pkg::COUNT_W-1:0]     accesses_seen = '0;
  logic [salc_pkg::COUNT_W-1:0]     misses_seen   = '0;

  trace_item_t            trace_q [$];
  tag_result_t            tag_result_q [$];

  apb_phase_e             apb_phase = APB_IDLE;
  int                     burst_left = 0;
  int                     gap_left = 0;
  int                     items_issued = 0;
  int                     results_done = 0;
  int                     err_cnt = 0;
  int                     cycle_cnt = 0;
  bit                     took;
  trace_item_t            head;

  set_associative_lru_cache_tags_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .address_i      (address_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .way_used_o     (way_used_o),
    .evicted_o      (evicted_o),
    .access_count_o (access_count_o),
    .miss_count_o   (miss_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < PRINT_LIMIT) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    err_cnt++;
  endtask

  task automatic clear_tags();
    foreach (valid_q[s, w]) begin
      valid_q[s][w] = 1'b0;
      rank_q[s][w]  = '0;
    end
    accesses_seen = '0;
    misses_seen   = '0;
  endtask

  task automatic apply_register_write(input logic [salc_pkg::PADDR_W-1:0] a,
                                      input logic [salc_pkg::PDATA_W-1:0] d);
    bit known;
    known = 1'b1;
    case (a[3:2])
      salc_pkg::REG_OFFSET: cfg_offset = d[salc_pkg::CFG_W-1:0];
      salc_pkg::REG_INDEX:  cfg_index  = d[salc_pkg::CFG_W-1:0];
      salc_pkg::REG_WAYS:   cfg_ways   = d[salc_pkg::CFG_W-1:0];
      default:              known = 1'b0;
    endcase
    if (known) clear_tags();
  endtask

  // make way w the most recent; valid ways younger than old_rank get older
  task automatic age_ways(input int s, input int w, input int nways, input int old_rank);
    for (int i = 0; i < nways; i++) begin
      if (i != w && valid_q[s][i] && rank_q[s][i] < old_rank && rank_q[s][i] < WAYS - 1)
        rank_q[s][i] = rank_q[s][i] + 1;
    end
    rank_q[s][w] = '0;
  endtask

  task automatic lookup_tags(input logic [31:0] addr);
    int          off;
    int          idx;
    int          nways;
    int          s;
    int          w;
    int          best;
    bit          found;
    logic [31:0] tg;
    tag_result_t r;
    off   = (cfg_offset > salc_pkg::OFFSET_LIMIT) ? salc_pkg::OFFSET_LIMIT : cfg_offset;
    idx   = (cfg_index > salc_pkg::INDEX_LIMIT) ? salc_pkg::INDEX_LIMIT : cfg_index;
    nways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : cfg_ways);
    s     = ((addr >> off) & ((32'd1 << idx) - 32'd1)) % SETS;
    tg    = addr >> (off + idx);
    r     = '0;
    w     = 0;
    if (accesses_seen != '1) accesses_seen++;
    for (int i = 0; i < nways; i++) begin
      if (!r.res.hit && valid_q[s][i] && tag_q[s][i] == tg) begin
        r.res.hit = 1'b1;
        w = i;
      end
    end
    if (r.res.hit) begin
      age_ways(s, w, nways, rank_q[s][w]);
    end else begin
      if (misses_seen != '1) misses_seen++;
      found = 1'b0;
      for (int i = 0; i < nways; i++) begin
        if (!found && !valid_q[s][i]) begin
          found = 1'b1;
          w = i;
        end
      end
      if (found) begin
        valid_q[s][w] = 1'b1;
        tag_q[s][w]   = tg;
        age_ways(s, w, nways, WAYS);
      end else begin
        best = 0;
        w    = 0;
        for (int i = 0; i < nways; i++) begin
          if (rank_q[s][i] > best) begin
            best = rank_q[s][i];
            w    = i;
          end
        end
        r.res.evicted = 1'b1;
        tag_q[s][w]   = tg;
        age_ways(s, w, nways, rank_q[s][w]);
      end
    end
    r.res.way  = w[salc_pkg::WAY_OUT_W-1:0];
    r.accesses = accesses_seen;
    r.misses   = misses_seen;
    tag_result_q.push_back(r);
  endtask

  task automatic queue_access(input logic [31:0] a);
    trace_item_t t;
    t.op       = OP_ACCESS;
    t.addr     = a;
    t.reg_addr = '0;
    t.reg_data = '0;
    trace_q.push_back(t);
  endtask

  task automatic queue_write(input logic [1:0] r, input logic [salc_pkg::CFG_W-1:0] v);
    trace_item_t t;
    t.op       = OP_WRITE;
    t.addr     = '0;
    t.reg_addr = {r, 2'b00};
    t.reg_data = ($urandom & 32'hFFFF_FFF0) | v;
    trace_q.push_back(t);
  endtask

  task automatic queue_drain();
    trace_item_t t;
    t.op       = OP_DRAIN;
    t.addr     = '0;
    t.reg_addr = '0;
    t.reg_data = '0;
    trace_q.push_back(t);
  endtask

  // set up one register setting and queue random accesses, mostly over hot sets
  task automatic queue_phase(input logic [salc_pkg::CFG_W-1:0] off_v,
                             input logic [salc_pkg::CFG_W-1:0] idx_v,
                             input logic [salc_pkg::CFG_W-1:0] ways_v, input int count);
    int          off;
    int          idx;
    int          nways;
    int          pool_size;
    int          pick;
    logic [31:0] pool [16];
    logic [31:0] hot [3];
    logic [31:0] set_mask;
    logic [31:0] set_v;
    logic [31:0] a;
    queue_write(salc_pkg::REG_OFFSET, off_v);
    queue_write(salc_pkg::REG_INDEX, idx_v);
    queue_write(salc_pkg::REG_WAYS, ways_v);
    off       = (off_v > salc_pkg::OFFSET_LIMIT) ? salc_pkg::OFFSET_LIMIT : off_v;
    idx       = (idx_v > salc_pkg::INDEX_LIMIT) ? salc_pkg::INDEX_LIMIT : idx_v;
    nways     = (ways_v == 0) ? 1 : ((ways_v > WAYS) ? WAYS : ways_v);
    pool_size = nways + 3;
    set_mask  = (32'd1 << idx) - 32'd1;
    foreach (pool[i]) pool[i] = $urandom;
    foreach (hot[i]) hot[i] = $urandom & set_mask;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        a = $urandom;
      end else begin
        set_v = (pick < 22) ? ($urandom & set_mask) : hot[$urandom_range(0, 2)];
        a = (pool[$urandom_range(0, pool_size - 1)] << (off + idx)) | (set_v << off)
            | ($urandom & ((32'd1 << off) - 32'd1));
      end
      queue_access(a);
      if (n == count / 2) queue_drain();
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      apb_phase <= APB_IDLE;
    end else if (apb_phase == APB_SETUP) begin
      penable   <= 1'b1;
      apb_phase <= APB_ACCESS;
    end else if (apb_phase == APB_ACCESS) begin
      if (pready) begin
        apply_register_write(paddr, pwdata);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        apb_phase <= APB_IDLE;
        gap_left  = $urandom_range(1, 4);
      end
    end else begin
      took = start && !busy;
      if (took) begin
        lookup_tags(address_i);
        void'(trace_q.pop_front());
        items_issued++;
      end
      if (start && !took) begin
        // hold the transaction until accepted
      end else if (trace_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        head = trace_q[0];
        case (head.op)
          OP_ACCESS: begin
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 48);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
            if (gap_left > 0) begin
              gap_left--;
              start <= 1'b0;
            end else begin
              start     <= 1'b1;
              address_i <= head.addr;
              burst_left--;
            end
          end
          OP_WRITE: begin
            start <= 1'b0;
            if (items_issued == results_done && !busy) begin
              psel      <= 1'b1;
              pwrite    <= 1'b1;
              paddr     <= head.reg_addr;
              pwdata    <= head.reg_data;
              apb_phase <= APB_SETUP;
              void'(trace_q.pop_front());
            end
          end
          default: begin
            start <= 1'b0;
            if (items_issued == results_done) void'(trace_q.pop_front());
          end
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tag_result_t want;
    if (rst_ni && result_valid_o) begin
      if (tag_result_q.size() == 0) begin
        report_mismatch("unexpected result", access_count_o, '0);
      end else begin
        want = tag_result_q.pop_front();
        if (hit_o !== want.res.hit) report_mismatch("hit", hit_o, want.res.hit);
        if (way_used_o !== want.res.way) report_mismatch("way_used", way_used_o, want.res.way);
        if (evicted_o !== want.res.evicted)
          report_mismatch("evicted", evicted_o, want.res.evicted);
        if (access_count_o !== want.accesses)
          report_mismatch("access_count", access_count_o, want.accesses);
        if (miss_count_o !== want.misses)
          report_mismatch("miss_count", miss_count_o, want.misses);
      end
      results_done <= results_done + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // reset setting, one way: fills, hits in the same block, evictions
    queue_access(32'h0000_0000);
    queue_access(32'h0000_003F);
    queue_access(32'hFFFF_FFFF);
    queue_access(32'hFFFF_FFC0);
    queue_access(32'h0000_0400);
    queue_access(32'h0000_0000);
    queue_access(32'h0000_0010);
    queue_access(32'hAAAA_AAAA);
    queue_access(32'h5555_5555);
    // unmapped register: ignored, contents kept
    queue_write(REG_SPARE, 4'h5);
    queue_access(32'h0000_0000);
    // one set, eight ways, no offset: fill all, then lru evictions
    queue_write(salc_pkg::REG_OFFSET, 4'd0);
    queue_write(salc_pkg::REG_INDEX, 4'd0);
    queue_write(salc_pkg::REG_WAYS, 4'd8);
    for (int i = 1; i <= 8; i++) queue_access(i);
    queue_access(32'd1);
    queue_access(32'd9);
    queue_access(32'd2);
    queue_access(32'hFFFF_FFFF);
    queue_access(32'd9);
    queue_drain();
    queue_phase(4'd3, 4'd2, 4'd4, 165);
    queue_phase(4'd12, 4'd9, 4'd8, 165);
    queue_phase(4'd15, 4'd15, 4'd15, 165);
    queue_phase(4'd13, 4'd10, 4'd0, 165);
    queue_phase(4'd2, 4'd1, 4'd2, 165);
    queue_phase(4'd0, 4'd3, 4'd3, 165);
    queue_phase(4'd5, 4'd5, 4'd9, 165);
    queue_phase(4'd1, 4'd0, 4'd5, 165);
    queue_phase(4'd4, 4'd2, 4'd7, 165);
    queue_phase(4'd6, 4'd4, 4'd1, 165);
    queue_phase(4'd0, 4'd9, 4'd8, 165);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (trace_q.size() != 0 || items_issued != results_done) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (tag_result_q.size() != 0)
      report_mismatch("results missing", tag_result_q.size(), 0);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/salc_pkg.sv
rtl/core/salc_ram.sv
rtl/core/salc_lookup.sv
rtl/core/set_associative_lru_cache_tags_top.sv
tb/tb_set_associative_lru_cache_tags_top.sv
